// ===== hw/rtl/hvn_pkg.sv =====
// Package for the hashed value noise block: field widths, register indices,
// reset values, noise mode codes and the hash constants.
// Depends on nothing; used by hashed_value_noise.
package hvn_pkg;

    // Field widths
    localparam int POS_W   = 48;
    localparam int FREQ_W  = 32;
    localparam int SEED_W  = 32;
    localparam int MODE_W  = 2;
    localparam int LEVEL_W = 16;
    localparam int IDX_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // Default fraction bits of the position
    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_MODE = 2'd2;

    // Reset values
    localparam logic [FREQ_W-1:0] FREQ_RST = 32'h0001_0000;
    localparam logic [SEED_W-1:0] SEED_RST = 32'h0000_0000;
    localparam logic [MODE_W-1:0] MODE_RST = 2'd2;

    // Noise mode codes; the unused code behaves as linear
    localparam logic [MODE_W-1:0] MODE_STEPPED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SMOOTH  = 2'd2;

    // Hash constants (lowbias32 style)
    localparam logic [31:0] HASH_GOLDEN = 32'h9e37_79b9;
    localparam logic [31:0] HASH_MUL1   = 32'h7feb_352d;
    localparam logic [31:0] HASH_MUL2   = 32'h846c_a68b;

    // Smoothstep constant 3.0 in Q2.16
    localparam logic [17:0] SMOOTH_THREE = 18'd196608;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [FRAC_W-1:0]  frac_t;
    typedef logic [LEVEL_W-1:0] level_t;

    // Seed mix and first xor-shift of the hash
    function automatic logic [31:0] hash_pre(input logic [31:0] idx,
                                             input logic [31:0] seed_k);
        logic [31:0] v;
        v = idx ^ seed_k;
        return v ^ (v >> 16);
    endfunction

endpackage

// ===== hw/rtl/hashed_value_noise.sv =====
// Top level of the hashed value noise block: six-stage pipeline from a
// fixed-point position to a 16-bit noise level. Depends on hvn_pkg.
//
// Throughput: one item per cycle; each stage holds one item and advances when
// the stage after it is empty or advancing, so bubbles absorb output stalls.
// Reset (aresetn low, synchronous): all stages empty, frequency 1.0,
// seed 0, noise mode smoothstep.
module hashed_value_noise
    import hvn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [POS_W-1:0]     s_tdata,   // [47:0] position
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [LEVEL_W-1:0]   m_tdata    // [15:0] level
);

    localparam int PROD_W = POS_W + FREQ_W;

    // Configuration registers
    logic [FREQ_W-1:0] freq_reg;
    logic [SEED_W-1:0] seed_reg;
    logic [MODE_W-1:0] mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg <= FREQ_RST;
            seed_reg <= SEED_RST;
            mode_reg <= MODE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FREQUENCY:  freq_reg <= cfg_wdata[FREQ_W-1:0];
                REG_SEED:       seed_reg <= cfg_wdata[SEED_W-1:0];
                REG_NOISE_MODE: mode_reg <= cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valids and advance enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !s6_valid_reg || m_tready;
    assign en5 = !s5_valid_reg || en6;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else begin
            if (en1) s1_valid_reg <= s_tvalid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
            if (en5) s5_valid_reg <= s4_valid_reg;
            if (en6) s6_valid_reg <= s5_valid_reg;
        end
    end

    // Stage 1: position times frequency as two partial products
    logic signed [64:0] s1_pp_lo_reg, s1_pp_lo_next;
    logic signed [47:0] s1_pp_hi_reg, s1_pp_hi_next;

    assign s1_pp_lo_next = $signed({33'b0, s_tdata[31:0]})
                         * $signed({{33{freq_reg[FREQ_W-1]}}, freq_reg});
    assign s1_pp_hi_next = $signed({{32{s_tdata[POS_W-1]}}, s_tdata[POS_W-1:32]})
                         * $signed({{16{freq_reg[FREQ_W-1]}}, freq_reg});

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_pp_lo_reg <= s1_pp_lo_next;
            s1_pp_hi_reg <= s1_pp_hi_next;
        end
    end

    // Stage 2: sum partial products, split lattice index and fraction
    logic [PROD_W-1:0] prod;
    idx_t  s2_index_reg;
    frac_t s2_frac_reg;

    assign prod = {s1_pp_hi_reg, 32'b0}
                + {{(PROD_W-65){s1_pp_lo_reg[64]}}, s1_pp_lo_reg};

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_index_reg <= prod[FRAC_BITS+16 +: IDX_W];
            s2_frac_reg  <= prod[FRAC_BITS +: FRAC_W];
        end
    end

    // Stage 3: seed mix and first hash multiply for both lattice points; f*f
    logic [31:0] seed_k, pre_a, pre_b;
    logic [31:0] s3_va_reg, s3_vb_reg, s3_ff_reg;
    frac_t s3_frac_reg;

    assign seed_k = seed_reg + HASH_GOLDEN;
    assign pre_a  = hash_pre(s2_index_reg, seed_k);
    assign pre_b  = hash_pre(s2_index_reg + 32'd1, seed_k);

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_va_reg   <= 32'(pre_a * HASH_MUL1);
            s3_vb_reg   <= 32'(pre_b * HASH_MUL1);
            s3_ff_reg   <= {16'b0, s2_frac_reg} * {16'b0, s2_frac_reg};
            s3_frac_reg <= s2_frac_reg;
        end
    end

    // Stage 4: second hash multiply; smoothstep weight
    logic [31:0] mid_a, mid_b;
    logic [17:0] smooth_k;
    logic [49:0] smooth_prod;
    logic [31:0] s4_va_reg, s4_vb_reg;
    frac_t s4_wsmooth_reg, s4_frac_reg;

    assign mid_a       = s3_va_reg ^ (s3_va_reg >> 15);
    assign mid_b       = s3_vb_reg ^ (s3_vb_reg >> 15);
    assign smooth_k    = SMOOTH_THREE - {1'b0, s3_frac_reg, 1'b0};
    assign smooth_prod = {18'b0, s3_ff_reg} * {32'b0, smooth_k};

    always_ff @(posedge aclk) begin
        if (en4) begin
            s4_va_reg      <= 32'(mid_a * HASH_MUL2);
            s4_vb_reg      <= 32'(mid_b * HASH_MUL2);
            s4_wsmooth_reg <= smooth_prod[47:32];
            s4_frac_reg    <= s3_frac_reg;
        end
    end

    // Stage 5: final xor-shift, weight select, interpolation products
    logic [31:0] fin_a, fin_b;
    level_t lvl_a, lvl_b;
    frac_t  weight;
    logic [16:0] weight_inv;
    logic [32:0] s5_pa_reg;
    logic [31:0] s5_pb_reg;
    level_t      s5_a_reg;

    assign fin_a = s4_va_reg ^ (s4_va_reg >> 16);
    assign fin_b = s4_vb_reg ^ (s4_vb_reg >> 16);
    assign lvl_a = fin_a[31:16];
    assign lvl_b = fin_b[31:16];

    always_comb begin
        unique case (mode_reg)
            MODE_SMOOTH: weight = s4_wsmooth_reg;
            default:     weight = s4_frac_reg;
        endcase
    end

    assign weight_inv = 17'h1_0000 - {1'b0, weight};

    always_ff @(posedge aclk) begin
        if (en5) begin
            s5_pa_reg <= {17'b0, lvl_a} * {16'b0, weight_inv};
            s5_pb_reg <= {16'b0, lvl_b} * {16'b0, weight};
            s5_a_reg  <= lvl_a;
        end
    end

    // Stage 6: blend sum or stepped level into the output register
    logic [32:0] blend;
    level_t      m_level_reg;

    assign blend = s5_pa_reg + {1'b0, s5_pb_reg};

    always_ff @(posedge aclk) begin
        if (en6) begin
            if (mode_reg == MODE_STEPPED) begin
                m_level_reg <= s5_a_reg;
            end else begin
                m_level_reg <= blend[31:16];
            end
        end
    end

    assign m_tvalid = s6_valid_reg;
    assign m_tdata  = m_level_reg;

    // Any empty stage means the input side can take a transfer
    a_ready_when_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s1_valid_reg || !s2_valid_reg || !s3_valid_reg || !s4_valid_reg ||
         !s5_valid_reg || !s6_valid_reg) |-> s_tready)
        else $error("input stalled with a free stage");

    // Input back-pressure only comes from a stalled output
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // Stepped mode passes the hashed level straight through
    a_stepped_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (en6 && s5_valid_reg && mode_reg == MODE_STEPPED && !cfg_wr_en)
        |=> m_tdata == $past(s5_a_reg))
        else $error("stepped level mismatch");

endmodule

// ===== bench/hashed_value_noise_test.sv =====
// Self-checking bench for hashed_value_noise: drives positions, predicts each noise
// level from the register settings and checks every level on the result stream.
// Depends on hvn_pkg and hashed_value_noise.
module hashed_value_noise_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hvn_pkg::*;

    localparam int FRAC_BITS = FRAC_BITS_DEF;
    localparam int LATENCY   = 6;
    // code that the block treats as linear
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [POS_W-1:0]     s_tdata   = '0;   // [47:0] position
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    level_t               m_tdata;          // [15:0] level

    // register copies for the predictor
    logic [FREQ_W-1:0] model_freq = FREQ_RST;
    logic [SEED_W-1:0] model_seed = SEED_RST;
    logic [MODE_W-1:0] model_mode = MODE_RST;

    level_t expected_levels[$];
    int     mismatch_count = 0;
    int     gap_pct        = 0;
    int     stall_pct      = 0;

    hashed_value_noise #(.FRAC_BITS(FRAC_BITS)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // overall guard against a hung pipeline
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    // lowbias32-style avalanche of a lattice index, top half kept
    function automatic level_t lattice_level(input idx_t idx, input logic [31:0] seed);
        logic [31:0] v;
        v = idx ^ (seed + HASH_GOLDEN);
        v = v ^ (v >> 16);
        v = v * HASH_MUL1;
        v = v ^ (v >> 15);
        v = v * HASH_MUL2;
        v = v ^ (v >> 16);
        return v[31:16];
    endfunction

    function automatic level_t noise_level_of(input logic [POS_W-1:0] pos);
        logic signed [POS_W+FREQ_W-1:0] phase;
        idx_t        lat_idx;
        logic [63:0] frac, wgt, lvl_a, lvl_b, mix;
        // exact signed product; floor and wrap come from two's complement
        phase   = $signed({{FREQ_W{pos[POS_W-1]}}, pos})
                * $signed({{POS_W{model_freq[FREQ_W-1]}}, model_freq});
        lat_idx = phase[FRAC_BITS+16 +: IDX_W];
        frac    = 64'(phase[FRAC_BITS +: FRAC_W]);
        lvl_a   = 64'(lattice_level(lat_idx, model_seed));
        if (model_mode == MODE_STEPPED)
            return lvl_a[LEVEL_W-1:0];
        lvl_b = 64'(lattice_level(lat_idx + 32'd1, model_seed));
        if (model_mode == MODE_SMOOTH)
            wgt = (frac * frac * (64'd196608 - 64'd2 * frac)) >> 32;
        else
            wgt = frac;
        mix = (lvl_a * (64'd65536 - wgt) + lvl_b * wgt) >> 16;
        return mix[LEVEL_W-1:0];
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // compare each result transfer with the oldest expected level; randomise tready
    always @(posedge aclk) begin
        level_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_levels.size() == 0) begin
                report_mismatch($sformatf("level %h with none outstanding", m_tdata));
            end else begin
                want = expected_levels.pop_front();
                if (m_tdata !== want)
                    report_mismatch($sformatf("level %h, expected %h", m_tdata, want));
            end
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ---------------------------------------------------------------- driving

    task automatic send_position(input logic [POS_W-1:0] pos);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pos;
        do @(posedge aclk); while (!s_tready);
        expected_levels.push_back(noise_level_of(pos));
    endtask

    // drop valid and wait until every outstanding level has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FREQUENCY:  model_freq = value;
            REG_SEED:       model_seed = value;
            REG_NOISE_MODE: model_mode = value[MODE_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] freq, input logic [CFG_W-1:0] seed,
                                 input logic [MODE_W-1:0] mode);
        wait_drained();
        set_register(REG_FREQUENCY, freq);
        set_register(REG_SEED, seed);
        set_register(REG_NOISE_MODE, CFG_W'(mode));
    endtask

    // ---------------------------------------------------------------- random values

    function automatic logic [POS_W-1:0] random_position();
        logic [63:0] raw;
        logic [POS_W-1:0] pos;
        raw = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0: pos = raw[POS_W-1:0];
            1: begin
                // near the origin, either sign
                pos = POS_W'($urandom_range(0, 32'h00FF_FFFF));
                if ($urandom_range(0, 1))
                    pos = -pos;
            end
            // on or just below a lattice point
            2: pos = {raw[31:0], ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
            default: pos = {raw[47:16] & 32'h0000_03FF | {32{raw[63]}} & 32'hFFFF_FC00,
                            raw[15:0]};
        endcase
        return pos;
    endfunction

    function automatic logic [CFG_W-1:0] random_frequency();
        logic [CFG_W-1:0] freq;
        case ($urandom_range(0, 4))
            0: freq = $urandom();
            1: freq = $urandom_range(1, 32'h0004_0000);
            2: freq = -$urandom_range(1, 32'h0004_0000);
            3: begin
                case ($urandom_range(0, 4))
                    0: freq = 32'h8000_0000;
                    1: freq = 32'h7FFF_FFFF;
                    2: freq = 32'h0000_0000;
                    3: freq = 32'h0000_0001;
                    default: freq = 32'hFFFF_FFFF;
                endcase
            end
            default: freq = 32'h0001_0000 + $urandom_range(0, 32'h0000_FFFF);
        endcase
        return freq;
    endfunction

    // ---------------------------------------------------------------- tests

    // reset values: frequency 1.0, seed 0, smoothstep
    task automatic test_reset_setting();
        send_position(48'h0000_0000_0000);
        send_position(48'h0000_0000_8000);
        send_position(48'hFFFF_FFFF_FFFF);
        send_position(48'h7FFF_FFFF_FFFF);
        send_position(48'h8000_0000_0000);
    endtask

    // every mode, including the spare code, mid-cell and across the index wrap
    task automatic test_each_mode();
        logic [MODE_W-1:0] modes[4];
        modes = '{MODE_STEPPED, MODE_LINEAR, MODE_SMOOTH, MODE_SPARE};
        foreach (modes[i]) begin
            wait_drained();
            set_register(REG_NOISE_MODE, CFG_W'(modes[i]));
            send_position(48'h0000_0001_4000);
            send_position(48'hFFFF_FFFF_8000);
        end
    endtask

    // frequency and seed at their limits, products far beyond 32 index bits
    task automatic test_extreme_products();
        apply_setting(32'h8000_0000, 32'h0000_0000, MODE_LINEAR);
        send_position(48'h7FFF_FFFF_FFFF);
        send_position(48'h8000_0000_0000);
        apply_setting(32'h7FFF_FFFF, 32'hFFFF_FFFF, MODE_SMOOTH);
        send_position(48'h7FFF_FFFF_FFFF);
        send_position(48'hFFFF_FFFF_FFFF);
        apply_setting(32'h0000_0000, 32'h6161_9E9E, MODE_STEPPED);
        send_position(48'h7FFF_FFFF_FFFF);
        apply_setting(32'hFFFF_0000, 32'hFFFF_FFFF, MODE_LINEAR);
        send_position(48'h0000_0001_FFFF);
    endtask

    // random settings and positions under each idling pattern
    task automatic test_random_stream(input int items_per_setting);
        int gaps[4], stalls[4];
        gaps   = '{0, 48, 0, 9};
        stalls = '{0, 0, 48, 9};
        for (int ph = 0; ph < 4; ph++) begin
            gap_pct   = gaps[ph];
            stall_pct = stalls[ph];
            for (int k = 0; k < 3; k++) begin
                apply_setting(random_frequency(), $urandom(), MODE_W'($urandom_range(0, 3)));
                repeat (items_per_setting)
                    send_position(random_position());
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_setting();
        test_each_mode();
        test_extreme_products();
        test_random_stream(137);

        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatch_count == 0 && expected_levels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
